FILE: src/pstd_pkg.sv
// ----------------------------------------------------------------------------
// pstd_pkg
// Shared widths, types and codes of the point to segment distance unit.
// ----------------------------------------------------------------------------
package pstd_pkg;

  localparam int COORD_W   = 24;               // signed Q15.8 coordinate
  localparam int DIFF_W    = COORD_W + 1;      // difference of two coordinates
  localparam int MAG_W     = COORD_W;          // magnitude of an end minus start
  localparam int SQ_W      = 2 * DIFF_W;       // signed product of two differences
  localparam int L2_W      = 2 * COORD_W + 2;  // squared length, three axes
  localparam int DOT_W     = L2_W + 1;         // signed dot product
  localparam int LEN_W     = L2_W / 2;         // integer square root of L2_W bits
  localparam int FRAC_BITS = 32;               // fraction bits of the projection
  localparam int T_W       = FRAC_BITS + 1;    // projection fraction in [0, 1]
  localparam int ALONG_Q_W = LEN_W + 1;        // magnitude of along before clamp
  localparam int OFF_W     = MAG_W + T_W;      // magnitude times fraction
  localparam int DIST_W    = 26;               // signed Q17.8 results
  localparam int REGION_W  = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [L2_W-1:0]           l2_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [T_W-1:0]            frac_t;
  typedef logic [ALONG_Q_W-1:0]      quot_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef enum logic [REGION_W-1:0] {
    REGION_WITHIN = 2'd0,
    REGION_BEFORE = 2'd1,
    REGION_PAST   = 2'd2
  } region_t;

endpackage

FILE: src/pstd_ifs.sv
// ----------------------------------------------------------------------------
// pstd channel interfaces
// Valid/ready channels for the query requests and the distance results.
// ----------------------------------------------------------------------------
interface pstd_in_if;
  import pstd_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (
    output valid, point_x, point_y, point_z, start_x, start_y, start_z,
           end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
           end_x, end_y, end_z,
    output ready
  );
endinterface

interface pstd_out_if;
  import pstd_pkg::*;

  logic                valid;
  logic                ready;
  dist_t               signed_distance;
  dist_t               along_ray;
  coord_t              point_on_ray_x;
  coord_t              point_on_ray_y;
  coord_t              point_on_ray_z;
  logic [REGION_W-1:0] region;

  modport source (
    output valid, signed_distance, along_ray, point_on_ray_x, point_on_ray_y,
           point_on_ray_z, region,
    input  ready
  );
  modport sink (
    input  valid, signed_distance, along_ray, point_on_ray_x, point_on_ray_y,
           point_on_ray_z, region,
    output ready
  );
endinterface

FILE: src/pstd_sqrt.sv
// ----------------------------------------------------------------------------
// pstd_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module pstd_sqrt #(
  parameter int IN_W   = pstd_pkg::L2_W,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       rad,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [(IN_W+1)/2-1:0] root,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int OUT_W = (IN_W + 1) / 2;
  localparam int PAD_W = 2 * OUT_W;
  localparam int REM_W = OUT_W + 2;

  logic [PAD_W-1:0]  rad_s  [0:OUT_W];
  logic [REM_W-1:0]  rem_s  [0:OUT_W];
  logic [OUT_W-1:0]  root_s [0:OUT_W];
  logic [SIDE_W-1:0] side_s [0:OUT_W];
  logic              vld_s  [0:OUT_W];

  assign rad_s[0]  = PAD_W'(rad);
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_in;
  assign vld_s[0]  = in_valid;

  for (genvar g = 0; g < OUT_W; g++) begin : g_step
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_nxt;
    logic [PAD_W-1:0]  rad_r;
    logic [REM_W-1:0]  rem_r;
    logic [OUT_W-1:0]  root_r;
    logic [SIDE_W-1:0] side_r;
    logic              vld_r;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh  = {rem_s[g][REM_W-3:0], rad_s[g][PAD_W-1 -: 2]};
    assign trial   = {root_s[g], 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_nxt = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= rad_s[g] << 2;
        rem_r  <= rem_nxt;
        root_r <= {root_s[g][OUT_W-2:0], ge};
        side_r <= side_s[g];
      end
    end

    assign rad_s[g+1]  = rad_r;
    assign rem_s[g+1]  = rem_r;
    assign root_s[g+1] = root_r;
    assign side_s[g+1] = side_r;
    assign vld_s[g+1]  = vld_r;
  end

  assign out_valid = vld_s[OUT_W];
  assign root      = root_s[OUT_W];
  assign side_out  = side_s[OUT_W];

endmodule

FILE: src/pstd_div.sv
// ----------------------------------------------------------------------------
// pstd_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module pstd_div #(
  parameter int DEN_W  = pstd_pkg::L2_W,
  parameter int Q_W    = pstd_pkg::T_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  num_hi,   // upper numerator bits, below den
  input  logic [Q_W-1:0]    num_lo,   // lower numerator bits, shifted in
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_s  [0:Q_W];
  logic [Q_W-1:0]    lo_s   [0:Q_W];
  logic [DEN_W-1:0]  den_s  [0:Q_W];
  logic [SIDE_W-1:0] side_s [0:Q_W];
  logic              vld_s  [0:Q_W];

  assign rem_s[0]  = num_hi;
  assign lo_s[0]   = num_lo;
  assign den_s[0]  = den;
  assign side_s[0] = side_in;
  assign vld_s[0]  = in_valid;

  for (genvar g = 0; g < Q_W; g++) begin : g_step
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    den_ext;
    logic [DEN_W:0]    rem_sub;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;
    logic [DEN_W-1:0]  rem_r;
    logic [Q_W-1:0]    lo_r;
    logic [DEN_W-1:0]  den_r;
    logic [SIDE_W-1:0] side_r;
    logic              vld_r;

    assign rem_sh  = {rem_s[g], lo_s[g][Q_W-1]};
    assign den_ext = {1'b0, den_s[g]};
    assign rem_sub = rem_sh - den_ext;
    assign ge      = (rem_sh >= den_ext);
    assign rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[g];
      end
    end

    // quotient bits fill in from the bottom as numerator bits leave the top
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        lo_r   <= {lo_s[g][Q_W-2:0], ge};
        den_r  <= den_s[g];
        side_r <= side_s[g];
      end
    end

    assign rem_s[g+1]  = rem_r;
    assign lo_s[g+1]   = lo_r;
    assign den_s[g+1]  = den_r;
    assign side_s[g+1] = side_r;
    assign vld_s[g+1]  = vld_r;
  end

  assign out_valid = vld_s[Q_W];
  assign quot      = lo_s[Q_W];
  assign side_out  = side_s[Q_W];

endmodule

FILE: src/point_to_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// point_to_segment_distance_unit
// Distance from a 3D point to a segment, with projection and closest point.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+------------------------------------------
//  in_ch   | in  | valid / ready | point, segment start, segment end (Q15.8)
//  out_ch  | out | valid / ready | signed distance, along, closest point, region
//
//  one request enters per cycle while in_ch.ready is high; each result passes
//  through two 25-stage square roots and 33- and 26-stage dividers
//  reset (rst_n low, synchronous) clears every stage valid bit; data is not reset
//  the whole pipeline advances when the output register is empty or taken,
//  so a stalled result holds every stage and in_ch.ready drops with it
//
module point_to_segment_distance_unit (
  input  logic       clk,
  input  logic       rst_n,
  pstd_in_if.sink    in_ch,
  pstd_out_if.source out_ch
);
  import pstd_pkg::*;

  localparam logic [OFF_W:0] HALF_LSB = (OFF_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [DIFF_W:0] COORD_MAX = (DIFF_W + 1)'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [DIFF_W:0] COORD_MIN = -(DIFF_W + 1)'(2 ** (COORD_W - 1));
  localparam dist_t DIST_MAX = dist_t'((2 ** (DIST_W - 1)) - 1);
  localparam dist_t DIST_MIN = -dist_t'(2 ** (DIST_W - 1));
  localparam quot_t ALONG_LIM = quot_t'(2 ** (DIST_W - 1));

  // sideband carried through the pipelined units
  typedef struct packed {
    logic [2:0][COORD_W-1:0] p;
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][COORD_W-1:0] e;
    logic [2:0][DIFF_W-1:0]  d;
    region_t                 region;
    logic                    neg;
    l2_t                     mag;
    l2_t                     l2;
  } side_a_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] p;
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][COORD_W-1:0] e;
    logic [2:0][DIFF_W-1:0]  d;
    region_t                 region;
    logic                    neg;
    l2_t                     mag;
    len_t                    len;
    logic                    l2_zero;
  } side_b_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] p;
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][COORD_W-1:0] e;
    logic [2:0][DIFF_W-1:0]  d;
    region_t                 region;
    logic                    neg;
    frac_t                   t;
    logic                    l2_zero;
  } side_c_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] q;
    region_t                 region;
    dist_t                   along;
  } side_d_t;

  logic adv;

  // front: input register, differences, products, sums
  logic   f0_vld_r;
  coord_t f0_p_r [3];
  coord_t f0_s_r [3];
  coord_t f0_e_r [3];

  logic   f1_vld_r;
  coord_t f1_p_r [3];
  coord_t f1_s_r [3];
  coord_t f1_e_r [3];
  diff_t  f1_d_r [3];
  diff_t  f1_t_r [3];
  diff_t  f1_d_nxt [3];
  diff_t  f1_t_nxt [3];

  logic                   f2_vld_r;
  coord_t                 f2_p_r [3];
  coord_t                 f2_s_r [3];
  coord_t                 f2_e_r [3];
  diff_t                  f2_d_r [3];
  logic signed [SQ_W-1:0] f2_dd_r [3];
  logic signed [SQ_W-1:0] f2_dt_r [3];

  logic   f3_vld_r;
  coord_t f3_p_r [3];
  coord_t f3_s_r [3];
  coord_t f3_e_r [3];
  diff_t  f3_d_r [3];
  l2_t    f3_l2_r;
  dot_t   f3_dot_r;
  l2_t    f3_l2_nxt;
  dot_t   f3_dot_nxt;

  side_a_t sa_in, sa_out;
  side_b_t sb_in, sb_out;
  side_c_t sc_in, sc_out;
  side_d_t sd_in, sd_out;
  logic    sa_vld, sb_vld, sc_vld, sd_vld;
  len_t    len;
  frac_t   frac;
  quot_t   along_q;
  len_t    dist_root;

  // back: scaled offsets, closest point, squared error, sum
  logic               b0_vld_r;
  logic [OFF_W-1:0]   b0_prod_r [3];
  logic               b0_dneg_r [3];
  coord_t             b0_p_r [3];
  coord_t             b0_s_r [3];
  coord_t             b0_e_r [3];
  region_t            b0_region_r;
  dist_t              b0_along_r;
  logic [OFF_W-1:0]   b0_prod_nxt [3];
  dist_t              b0_along_nxt;

  logic    b1_vld_r;
  coord_t  b1_p_r [3];
  coord_t  b1_q_r [3];
  region_t b1_region_r;
  dist_t   b1_along_r;
  coord_t  b1_q_nxt [3];

  logic    b2_vld_r;
  l2_t     b2_sq_r [3];
  coord_t  b2_q_r [3];
  region_t b2_region_r;
  dist_t   b2_along_r;
  l2_t     b2_sq_nxt [3];

  logic    b3_vld_r;
  l2_t     b3_sum_r;
  coord_t  b3_q_r [3];
  region_t b3_region_r;
  dist_t   b3_along_r;

  logic    out_vld_r;
  dist_t   out_dist_r;
  dist_t   out_along_r;
  coord_t  out_q_r [3];
  region_t out_region_r;
  dist_t   out_dist_nxt;

  // every stage moves together while the output register can take a result
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r  <= 1'b0;
      f1_vld_r  <= 1'b0;
      f2_vld_r  <= 1'b0;
      f3_vld_r  <= 1'b0;
      b0_vld_r  <= 1'b0;
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      b3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      f0_vld_r  <= in_ch.valid;
      f1_vld_r  <= f0_vld_r;
      f2_vld_r  <= f1_vld_r;
      f3_vld_r  <= f2_vld_r;
      b0_vld_r  <= sc_vld;
      b1_vld_r  <= b0_vld_r;
      b2_vld_r  <= b1_vld_r;
      b3_vld_r  <= b2_vld_r;
      out_vld_r <= sd_vld;
    end
  end

  // ---------------------------------------------------------------- front
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f1_d_nxt[i] = diff_t'(f0_e_r[i]) - diff_t'(f0_s_r[i]);
      f1_t_nxt[i] = diff_t'(f0_p_r[i]) - diff_t'(f0_s_r[i]);
    end
  end

  // squared length and dot product are exact
  always_comb begin
    f3_l2_nxt  = L2_W'($unsigned(f2_dd_r[0])) + L2_W'($unsigned(f2_dd_r[1]))
               + L2_W'($unsigned(f2_dd_r[2]));
    f3_dot_nxt = dot_t'(f2_dt_r[0]) + dot_t'(f2_dt_r[1]) + dot_t'(f2_dt_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_p_r[0] <= in_ch.point_x;
      f0_p_r[1] <= in_ch.point_y;
      f0_p_r[2] <= in_ch.point_z;
      f0_s_r[0] <= in_ch.start_x;
      f0_s_r[1] <= in_ch.start_y;
      f0_s_r[2] <= in_ch.start_z;
      f0_e_r[0] <= in_ch.end_x;
      f0_e_r[1] <= in_ch.end_y;
      f0_e_r[2] <= in_ch.end_z;
      for (int i = 0; i < 3; i++) begin
        f1_p_r[i]  <= f0_p_r[i];
        f1_s_r[i]  <= f0_s_r[i];
        f1_e_r[i]  <= f0_e_r[i];
        f1_d_r[i]  <= f1_d_nxt[i];
        f1_t_r[i]  <= f1_t_nxt[i];
        f2_p_r[i]  <= f1_p_r[i];
        f2_s_r[i]  <= f1_s_r[i];
        f2_e_r[i]  <= f1_e_r[i];
        f2_d_r[i]  <= f1_d_r[i];
        f2_dd_r[i] <= f1_d_r[i] * f1_d_r[i];
        f2_dt_r[i] <= f1_d_r[i] * f1_t_r[i];
        f3_p_r[i]  <= f2_p_r[i];
        f3_s_r[i]  <= f2_s_r[i];
        f3_e_r[i]  <= f2_e_r[i];
        f3_d_r[i]  <= f2_d_r[i];
      end
      f3_l2_r  <= f3_l2_nxt;
      f3_dot_r <= f3_dot_nxt;
    end
  end

  // region split: a projection exactly on an end counts as within
  always_comb begin
    dot_t mag_full;
    mag_full = f3_dot_r[DOT_W-1] ? -f3_dot_r : f3_dot_r;
    for (int i = 0; i < 3; i++) begin
      sa_in.p[i] = f3_p_r[i];
      sa_in.s[i] = f3_s_r[i];
      sa_in.e[i] = f3_e_r[i];
      sa_in.d[i] = f3_d_r[i];
    end
    sa_in.neg = f3_dot_r[DOT_W-1];
    sa_in.mag = mag_full[L2_W-1:0];
    sa_in.l2  = f3_l2_r;
    if (f3_dot_r[DOT_W-1]) begin
      sa_in.region = REGION_BEFORE;
    end else if (f3_dot_r[L2_W-1:0] > f3_l2_r) begin
      sa_in.region = REGION_PAST;
    end else begin
      sa_in.region = REGION_WITHIN;
    end
  end

  // segment length
  pstd_sqrt #(
    .IN_W   (L2_W),
    .SIDE_W ($bits(side_a_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f3_vld_r),
    .rad       (f3_l2_r),
    .side_in   (sa_in),
    .out_valid (sa_vld),
    .root      (len),
    .side_out  (sa_out)
  );

  always_comb begin
    sb_in.p       = sa_out.p;
    sb_in.s       = sa_out.s;
    sb_in.e       = sa_out.e;
    sb_in.d       = sa_out.d;
    sb_in.region  = sa_out.region;
    sb_in.neg     = sa_out.neg;
    sb_in.mag     = sa_out.mag;
    sb_in.len     = len;
    sb_in.l2_zero = (sa_out.l2 == '0);
  end

  // projection fraction dot/L2 in Q1.32, meaningful only within the segment
  pstd_div #(
    .DEN_W  (L2_W),
    .Q_W    (T_W),
    .SIDE_W ($bits(side_b_t))
  ) u_frac_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sa_vld),
    .num_hi    ({1'b0, sa_out.mag[L2_W-1:1]}),
    .num_lo    ({sa_out.mag[0], {FRAC_BITS{1'b0}}}),
    .den       (sa_out.l2),
    .side_in   (sb_in),
    .out_valid (sb_vld),
    .quot      (frac),
    .side_out  (sb_out)
  );

  always_comb begin
    sc_in.p       = sb_out.p;
    sc_in.s       = sb_out.s;
    sc_in.e       = sb_out.e;
    sc_in.d       = sb_out.d;
    sc_in.region  = sb_out.region;
    sc_in.neg     = sb_out.neg;
    sc_in.t       = sb_out.l2_zero ? '0 : frac;
    sc_in.l2_zero = sb_out.l2_zero;
  end

  // |dot| / len stays below 2^26, so the upper numerator part is below len
  pstd_div #(
    .DEN_W  (LEN_W),
    .Q_W    (ALONG_Q_W),
    .SIDE_W ($bits(side_c_t))
  ) u_along_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sb_vld),
    .num_hi    (LEN_W'(sb_out.mag >> ALONG_Q_W)),
    .num_lo    (sb_out.mag[ALONG_Q_W-1:0]),
    .den       (sb_out.len),
    .side_in   (sc_in),
    .out_valid (sc_vld),
    .quot      (along_q),
    .side_out  (sc_out)
  );

  // ---------------------------------------------------------------- back
  // along: signed, clamped, zero for a zero-length segment
  always_comb begin
    if (sc_out.l2_zero) begin
      b0_along_nxt = '0;
    end else if (!sc_out.neg) begin
      b0_along_nxt = along_q[ALONG_Q_W-1] ? DIST_MAX : dist_t'(along_q);
    end else begin
      b0_along_nxt = (along_q > ALONG_LIM) ? DIST_MIN : -dist_t'(along_q);
    end
  end

  always_comb begin
    diff_t d_i;
    diff_t d_abs;
    for (int i = 0; i < 3; i++) begin
      d_i            = diff_t'(sc_out.d[i]);
      d_abs          = d_i[DIFF_W-1] ? -d_i : d_i;
      b0_prod_nxt[i] = OFF_W'(d_abs[MAG_W-1:0]) * OFF_W'(sc_out.t);
    end
  end

  // closest point: start plus rounded offset within, else the nearer end
  always_comb begin
    logic [OFF_W:0]          rnd;
    diff_t                   off;
    diff_t                   so;
    logic signed [DIFF_W:0]  sum;
    coord_t                  qs;
    for (int i = 0; i < 3; i++) begin
      rnd = {1'b0, b0_prod_r[i]} + HALF_LSB;
      off = rnd[FRAC_BITS +: DIFF_W];
      so  = b0_dneg_r[i] ? -off : off;
      sum = (DIFF_W + 1)'(b0_s_r[i]) + (DIFF_W + 1)'(so);
      if (sum > COORD_MAX) begin
        qs = COORD_MAX[COORD_W-1:0];
      end else if (sum < COORD_MIN) begin
        qs = COORD_MIN[COORD_W-1:0];
      end else begin
        qs = sum[COORD_W-1:0];
      end
      case (b0_region_r)
        REGION_BEFORE: b1_q_nxt[i] = b0_s_r[i];
        REGION_PAST:   b1_q_nxt[i] = b0_e_r[i];
        default:       b1_q_nxt[i] = qs;
      endcase
    end
  end

  always_comb begin
    diff_t dq;
    logic signed [SQ_W-1:0] sq;
    for (int i = 0; i < 3; i++) begin
      dq           = diff_t'(b1_p_r[i]) - diff_t'(b1_q_r[i]);
      sq           = dq * dq;
      b2_sq_nxt[i] = L2_W'($unsigned(sq));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b0_prod_r[i] <= b0_prod_nxt[i];
        b0_dneg_r[i] <= sc_out.d[i][DIFF_W-1];
        b0_p_r[i]    <= sc_out.p[i];
        b0_s_r[i]    <= sc_out.s[i];
        b0_e_r[i]    <= sc_out.e[i];
        b1_p_r[i]    <= b0_p_r[i];
        b1_q_r[i]    <= b1_q_nxt[i];
        b2_sq_r[i]   <= b2_sq_nxt[i];
        b2_q_r[i]    <= b1_q_r[i];
        b3_q_r[i]    <= b2_q_r[i];
      end
      b0_region_r <= sc_out.region;
      b0_along_r  <= b0_along_nxt;
      b1_region_r <= b0_region_r;
      b1_along_r  <= b0_along_r;
      b2_region_r <= b1_region_r;
      b2_along_r  <= b1_along_r;
      b3_sum_r    <= b2_sq_r[0] + b2_sq_r[1] + b2_sq_r[2];
      b3_region_r <= b2_region_r;
      b3_along_r  <= b2_along_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd_in.q[i] = b3_q_r[i];
    end
    sd_in.region = b3_region_r;
    sd_in.along  = b3_along_r;
  end

  // distance to the closest point; it stays below 2^25, so no clamp is needed
  pstd_sqrt #(
    .IN_W   (L2_W),
    .SIDE_W ($bits(side_d_t))
  ) u_dist_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (b3_vld_r),
    .rad       (b3_sum_r),
    .side_in   (sd_in),
    .out_valid (sd_vld),
    .root      (dist_root),
    .side_out  (sd_out)
  );

  assign out_dist_nxt = (sd_out.region == REGION_WITHIN) ? dist_t'(dist_root)
                                                         : -dist_t'(dist_root);

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r   <= out_dist_nxt;
      out_along_r  <= sd_out.along;
      out_region_r <= sd_out.region;
      for (int i = 0; i < 3; i++) begin
        out_q_r[i] <= sd_out.q[i];
      end
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.signed_distance = out_dist_r;
  assign out_ch.along_ray       = out_along_r;
  assign out_ch.point_on_ray_x  = out_q_r[0];
  assign out_ch.point_on_ray_y  = out_q_r[1];
  assign out_ch.point_on_ray_z  = out_q_r[2];
  assign out_ch.region          = out_region_r;

  // ---------------------------------------------------------------- checks
  // outside the segment the point is never on the end, so distance is negative
  a_outside_negative : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_region_r != REGION_WITHIN) |-> out_dist_r[DIST_W-1])
    else $error("outside result without negative distance");

  a_within_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_region_r == REGION_WITHIN) |-> !out_dist_r[DIST_W-1])
    else $error("within result with negative distance");

  a_before_along : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_region_r == REGION_BEFORE)
      |-> (out_along_r[DIST_W-1] || (out_along_r == '0)))
    else $error("before-start result with positive along");

  a_after_along : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_region_r != REGION_BEFORE) |-> !out_along_r[DIST_W-1])
    else $error("forward result with negative along");

endmodule

FILE: tb/sv/point_to_segment_distance_unit_test.sv
// ----------------------------------------------------------------------------
// point_to_segment_distance_unit_test
// Streams point and segment queries through the unit under four idling
// phases. Each accepted request is run through an integer predictor, and
// every result is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module point_to_segment_distance_unit_test;
  import pstd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY     = 118;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  HOLD_CYCLES = 400;
  localparam longint CMIN     = -(64'sd1 <<< (COORD_W - 1));
  localparam longint CMAX     = (64'sd1 <<< (COORD_W - 1)) - 1;

  typedef struct packed {
    coord_t px, py, pz;
    coord_t sx, sy, sz;
    coord_t ex, ey, ez;
  } query_t;

  typedef struct packed {
    dist_t   distance;
    dist_t   along;
    coord_t  cx, cy, cz;
    region_t region;
  } nearest_t;

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // closest point on the segment, distance, projection and region
  function automatic nearest_t predict_nearest(query_t q);
    longint p[3], s[3], e[3], d[3], c[3];
    longint dot, along, dist_v, df, so;
    longint unsigned l2, len, mag, t, m, off, sq;
    logic [127:0] num;
    nearest_t r;
    p = '{longint'(q.px), longint'(q.py), longint'(q.pz)};
    s = '{longint'(q.sx), longint'(q.sy), longint'(q.sz)};
    e = '{longint'(q.ex), longint'(q.ey), longint'(q.ez)};
    dot = 0;
    l2  = 0;
    along = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = e[i] - s[i];
      l2  += longint'(d[i] * d[i]);
      dot += d[i] * (p[i] - s[i]);
    end
    if (l2 != 0) begin
      len   = floor_sqrt(l2);
      mag   = (dot < 0) ? -dot : dot;
      along = (dot < 0) ? -longint'(mag / len) : longint'(mag / len);
    end
    if (dot < 0) begin
      r.region = REGION_BEFORE;
      c = s;
    end else if (longint'(dot) > longint'(l2)) begin
      r.region = REGION_PAST;
      c = e;
    end else begin
      r.region = REGION_WITHIN;
      t = 0;
      if (l2 != 0) begin
        num = 128'(dot) << FRAC_BITS;
        t   = 64'(num / 128'(l2));
      end
      for (int i = 0; i < 3; i++) begin
        m    = (d[i] < 0) ? -d[i] : d[i];
        off  = (m * t + (64'd1 << 31)) >> 32;
        so   = (d[i] < 0) ? -longint'(off) : longint'(off);
        c[i] = clamp(s[i] + so, COORD_W);
      end
    end
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      df  = p[i] - c[i];
      sq += df * df;
    end
    dist_v = floor_sqrt(sq);
    if (r.region != REGION_WITHIN) dist_v = -dist_v;
    r.distance = dist_t'(clamp(dist_v, DIST_W));
    r.along    = dist_t'(clamp(along, DIST_W));
    r.cx = coord_t'(c[0]);
    r.cy = coord_t'(c[1]);
    r.cz = coord_t'(c[2]);
    return r;
  endfunction

  // in-order store of predicted results
  class nearest_book;
    nearest_t pending_q[$];

    function void note_query(query_t q);
      pending_q.push_back(predict_nearest(q));
    endfunction

    // returns an empty string when the result matches
    function string check_result(nearest_t got);
      nearest_t want;
      string    msg;
      if (pending_q.size() == 0) return "result with no request outstanding";
      want = pending_q.pop_front();
      msg  = "";
      if (got.distance !== want.distance)
        msg = {msg, $sformatf(" distance %0d/%0d", got.distance, want.distance)};
      if (got.along !== want.along)
        msg = {msg, $sformatf(" along %0d/%0d", got.along, want.along)};
      if (got.cx !== want.cx) msg = {msg, $sformatf(" cx %0d/%0d", got.cx, want.cx)};
      if (got.cy !== want.cy) msg = {msg, $sformatf(" cy %0d/%0d", got.cy, want.cy)};
      if (got.cz !== want.cz) msg = {msg, $sformatf(" cz %0d/%0d", got.cz, want.cz)};
      if (got.region !== want.region)
        msg = {msg, $sformatf(" region %0d/%0d", got.region, want.region)};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   errors;
  int   cycles;
  int   results_seen;

  // idling knobs, percent of cycles, and the length of a receiver hold-off
  int   sender_idle_pct;
  int   recv_stall_pct;
  int   hold_left;

  nearest_book book;

  pstd_in_if  in_ch ();
  pstd_out_if out_ch ();

  point_to_segment_distance_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d:%s", cycles, what);
  endtask

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** point_to_segment_distance_unit: FAILED **");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    nearest_t got;
    string    msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.distance = out_ch.signed_distance;
      got.along    = out_ch.along_ray;
      got.cx       = out_ch.point_on_ray_x;
      got.cy       = out_ch.point_on_ray_y;
      got.cz       = out_ch.point_on_ray_z;
      got.region   = region_t'(out_ch.region);
      msg = book.check_result(got);
      if (msg != "") report(msg);
      results_seen++;
    end
  end

  // receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic query_t make_query(longint px, longint py, longint pz,
                                        longint sx, longint sy, longint sz,
                                        longint ex, longint ey, longint ez);
    query_t q;
    q = '{coord_t'(px), coord_t'(py), coord_t'(pz), coord_t'(sx), coord_t'(sy),
          coord_t'(sz), coord_t'(ex), coord_t'(ey), coord_t'(ez)};
    return q;
  endfunction

  // one request: optional idle gap, then hold valid until taken
  task automatic send_request(query_t q);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    {in_ch.point_x, in_ch.point_y, in_ch.point_z} = {q.px, q.py, q.pz};
    {in_ch.start_x, in_ch.start_y, in_ch.start_z} = {q.sx, q.sy, q.sz};
    {in_ch.end_x, in_ch.end_y, in_ch.end_z}       = {q.ex, q.ey, q.ez};
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    book.note_query(q);
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_ch.valid = 1'b0;
    while (book.pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t pick_coord(int span);
    if (span >= COORD_W) return coord_t'($urandom);
    return coord_t'($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
  endfunction

  // random query, mostly well-formed geometry with varied scale
  function automatic query_t random_query();
    query_t q;
    int     span;
    int     kind;
    int     f;
    kind = $urandom_range(99);
    span = (kind < 35) ? COORD_W : $urandom_range(COORD_W - 1, 3);
    q = make_query(pick_coord(span), pick_coord(span), pick_coord(span),
                   pick_coord(span), pick_coord(span), pick_coord(span),
                   pick_coord(span), pick_coord(span), pick_coord(span));
    if (kind >= 90) begin
      // degenerate segment, point sometimes on it
      {q.ex, q.ey, q.ez} = {q.sx, q.sy, q.sz};
      if ($urandom_range(1)) {q.px, q.py, q.pz} = {q.sx, q.sy, q.sz};
    end else if (kind >= 80) begin
      // point sitting on an end
      if ($urandom_range(1)) {q.px, q.py, q.pz} = {q.sx, q.sy, q.sz};
      else {q.px, q.py, q.pz} = {q.ex, q.ey, q.ez};
    end else if (kind >= 55 && span < COORD_W - 2) begin
      // point near an interior spot of the segment
      f = $urandom_range(16);
      q.px = coord_t'(q.sx + ((q.ex - q.sx) * f) / 16 + pick_coord(4));
      q.py = coord_t'(q.sy + ((q.ey - q.sy) * f) / 16 + pick_coord(4));
      q.pz = coord_t'(q.sz + ((q.ez - q.sz) * f) / 16 + pick_coord(4));
    end
    return q;
  endfunction

  initial begin
    query_t directed_q[$];
    int     phase_items[4];
    int     idle_pct[4];
    int     stall_pct[4];
    int     wait_left;

    book = new();
    errors = 0;
    cycles = 0;
    results_seen = 0;
    hold_left = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.point_x, in_ch.point_y, in_ch.point_z} = '0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z} = '0;
    {in_ch.end_x, in_ch.end_y, in_ch.end_z} = '0;
    out_ch.ready = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero-length segments, ends, regions, extremes, rounding
    directed_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_query(-5000, 77, 3, 100, 100, 100, 100, 100, 100));
    directed_q.push_back(make_query(0, 0, 0, 0, 0, 0, 1000, 0, 0));
    directed_q.push_back(make_query(1000, 0, 0, 0, 0, 0, 1000, 0, 0));
    directed_q.push_back(make_query(-500, 20, 0, 0, 0, 0, 1000, 0, 0));
    directed_q.push_back(make_query(1500, 7, 0, 0, 0, 0, 1000, 0, 0));
    directed_q.push_back(make_query(400, 300, -200, 0, 0, 0, 1000, 0, 0));
    directed_q.push_back(make_query(1, 5, 0, 0, 0, 0, 3, 1, 0));
    directed_q.push_back(make_query(-7, 2, 9, 10, 10, 10, -10, -3, 5));
    directed_q.push_back(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    directed_q.push_back(make_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    directed_q.push_back(make_query(0, 0, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    directed_q.push_back(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    directed_q.push_back(make_query(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    directed_q.push_back(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX - 1, CMAX, CMAX));
    directed_q.push_back(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN + 1, CMIN, CMIN));
    directed_q.push_back(make_query(CMIN, 0, 0, CMAX, 0, 0, CMAX - 256, 0, 0));
    directed_q.push_back(make_query(CMAX, CMIN, 0, 0, CMAX, 0, 0, CMIN, 0));
    directed_q.push_back(make_query(3, -4, 5, -1, -1, -1, 1, 1, 1));
    directed_q.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    foreach (directed_q[i]) send_request(directed_q[i]);
    go_quiet();

    // random phases: none, sender idle, receiver stall, both
    phase_items = '{300, 280, 280, 270};
    idle_pct    = '{0, 55, 0, 19};
    stall_pct   = '{0, 0, 55, 19};
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_pct[ph];
      recv_stall_pct  = stall_pct[ph];
      // first phase starts under a long receiver hold-off so the pipe backs up
      if (ph == 0) hold_left = HOLD_CYCLES;
      for (int n = 0; n < phase_items[ph]; n++) begin
        // quiet stretches with no idling inside the random phases
        if (ph != 0 && n == phase_items[ph] / 2) begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        send_request(random_query());
      end
      // sender pauses until every result has come back
      go_quiet();
    end

    // drain then let any stray result show up
    wait_left = LATENCY + 32;
    while (wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    if (errors == 0 && book.pending_q.size() == 0) begin
      $display("** point_to_segment_distance_unit: PASSED **");
    end else begin
      $display("** point_to_segment_distance_unit: FAILED **");
    end
    $finish;
  end

endmodule
